/* sv/tesh_pkg.sv */
// Shared constants and character helpers for the tab-expanding highlighter.
package tesh_pkg;

    localparam int TAB_STOP_DEF = 8;

    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_DOT       = 8'h2E;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

    localparam logic [1:0] COLOR_DEFAULT = 2'd0;
    localparam logic [1:0] COLOR_NUMBER  = 2'd1;
    localparam logic [1:0] COLOR_STRING  = 2'd2;

    localparam logic [1:0] QUOTE_NONE   = 2'd0;
    localparam logic [1:0] QUOTE_DOUBLE = 2'd1;
    localparam logic [1:0] QUOTE_SINGLE = 2'd2;

    localparam logic REG_HL_NUMBERS = 1'b0;
    localparam logic REG_HL_STRINGS = 1'b1;

    function automatic logic is_separator(input logic [7:0] c);
        logic sep;
        sep = 1'b0;
        if (c == CHAR_NUL || c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR)) begin
            sep = 1'b1;
        end
        case (c)
            8'h2C, 8'h2E, 8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h3D,
            8'h7E, 8'h25, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h3B, 8'h27, 8'h22: begin
                sep = 1'b1;
            end
            default: begin
            end
        endcase
        return sep;
    endfunction

    function automatic logic [1:0] quote_code(input logic [7:0] c);
        logic [1:0] q;
        case (c)
            CHAR_DQUOTE: q = QUOTE_DOUBLE;
            CHAR_SQUOTE: q = QUOTE_SINGLE;
            default:     q = QUOTE_NONE;
        endcase
        return q;
    endfunction

endpackage

/* sv/tab_expand_syntax_highlighter.sv */
// Tab-expanding syntax highlighter: renders one source byte stream with color classes.
//
// One source byte is accepted per cycle while the output is not stalled and no tab is
// still being expanded; a non-tab byte produces one rendered beat. A tab expands to
// TAB_STOP minus the current column spaces (1 to TAB_STOP) and holds the work stage
// until its last space, since the single result register emits one rendered byte per
// cycle while the output is not stalled. A set tuser bit on an input beat starts a new
// row and clears the column and highlight state. Configuration writes must be issued only
// while no input beat is in flight.
module tab_expand_syntax_highlighter #(
    parameter int TAB_STOP = tesh_pkg::TAB_STOP_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration write port
    input  logic       cfg_wr_en,
    input  logic       cfg_addr,
    input  logic       cfg_wdata,
    // source byte stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    input  logic       s_tuser,   // [0] row_start
    // rendered byte stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] render_char
    output logic [1:0] m_tuser,   // [1:0] color
    output logic       m_tlast    // last_of_run
);

    localparam int COL_W = (TAB_STOP > 2) ? $clog2(TAB_STOP) : 1;
    localparam logic [COL_W-1:0] COL_MAX = COL_W'(TAB_STOP - 1);

    // configuration
    logic hl_numbers_reg;
    logic hl_strings_reg;

    // row highlight state
    logic [COL_W-1:0] col_reg;
    logic [1:0]       open_quote_reg;
    logic             prev_sep_reg;
    logic             prev_num_reg;
    logic             prev_bs_reg;

    // work stage
    logic       work_valid_reg;
    logic [7:0] work_char_reg;
    logic       work_row_start_reg;

    // result register
    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic [1:0] out_color_reg;
    logic       out_last_reg;

    logic [COL_W-1:0] col_eff;
    logic [1:0]       quote_eff;
    logic             sep_eff;
    logic             num_eff;
    logic             bs_eff;
    logic             is_tab;
    logic [7:0]       rchar;
    logic [1:0]       qcode;
    logic [1:0]       open_quote_next;
    logic             is_string;
    logic [1:0]       color;
    logic             beat_last;
    logic [COL_W-1:0] col_next;
    logic             out_free;
    logic             beat_fire;
    logic             in_accept;

    always_comb begin
        if (work_row_start_reg) begin
            col_eff   = '0;
            quote_eff = tesh_pkg::QUOTE_NONE;
            sep_eff   = 1'b1;
            num_eff   = 1'b0;
            bs_eff    = 1'b0;
        end else begin
            col_eff   = col_reg;
            quote_eff = open_quote_reg;
            sep_eff   = prev_sep_reg;
            num_eff   = prev_num_reg;
            bs_eff    = prev_bs_reg;
        end

        is_tab = (work_char_reg == tesh_pkg::CHAR_TAB);
        rchar  = is_tab ? tesh_pkg::CHAR_SPACE : work_char_reg;
        qcode  = tesh_pkg::quote_code(rchar);

        open_quote_next = quote_eff;
        is_string       = 1'b0;
        if (hl_strings_reg) begin
            if (quote_eff != tesh_pkg::QUOTE_NONE) begin
                if (qcode == quote_eff && !bs_eff) begin
                    open_quote_next = tesh_pkg::QUOTE_NONE;
                end
                is_string = 1'b1;
            end else if (qcode != tesh_pkg::QUOTE_NONE) begin
                open_quote_next = qcode;
                is_string       = 1'b1;
            end
        end

        // a dot continues a number even if number coloring was just switched off
        if (is_string) begin
            color = tesh_pkg::COLOR_STRING;
        end else if ((hl_numbers_reg && rchar >= tesh_pkg::CHAR_ZERO &&
                      rchar <= tesh_pkg::CHAR_NINE && (sep_eff || num_eff)) ||
                     (rchar == tesh_pkg::CHAR_DOT && num_eff)) begin
            color = tesh_pkg::COLOR_NUMBER;
        end else begin
            color = tesh_pkg::COLOR_DEFAULT;
        end

        // tab beats step the column like any byte; the tab ends where the column wraps
        beat_last = !is_tab || (col_eff == COL_MAX);
        col_next  = (col_eff == COL_MAX) ? '0 : col_eff + COL_W'(1);

        out_free  = !out_valid_reg || m_tready;
        beat_fire = work_valid_reg && out_free;
        s_tready  = !work_valid_reg || (out_free && beat_last);
        in_accept = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hl_numbers_reg <= 1'b0;
            hl_strings_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                tesh_pkg::REG_HL_NUMBERS: hl_numbers_reg <= cfg_wdata;
                tesh_pkg::REG_HL_STRINGS: hl_strings_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            open_quote_reg <= tesh_pkg::QUOTE_NONE;
            prev_sep_reg   <= 1'b1;
            prev_num_reg   <= 1'b0;
            prev_bs_reg    <= 1'b0;
        end else if (beat_fire) begin
            col_reg        <= col_next;
            open_quote_reg <= open_quote_next;
            prev_sep_reg   <= tesh_pkg::is_separator(rchar);
            prev_num_reg   <= (color == tesh_pkg::COLOR_NUMBER);
            prev_bs_reg    <= (rchar == tesh_pkg::CHAR_BACKSLASH);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg     <= 1'b0;
            work_row_start_reg <= 1'b0;
        end else if (in_accept) begin
            work_valid_reg     <= 1'b1;
            work_row_start_reg <= s_tuser;
        end else if (beat_fire) begin
            work_valid_reg     <= !beat_last;
            work_row_start_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            work_char_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (beat_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_fire) begin
            out_char_reg  <= rchar;
            out_color_reg <= color;
            out_last_reg  <= beat_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_color_reg;
    assign m_tlast  = out_last_reg;

endmodule

/* sv/tesh_checker.sv */
// Port-level assertions for the tab-expanding highlighter, bound to the top level.
module tesh_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // a held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // no result beat right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // only the spaces of a tab can be non-final beats
    a_nonspace_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata != tesh_pkg::CHAR_SPACE |-> m_tlast)
        else $error("non-space beat not marked last");

    // color code 3 is never produced
    a_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("illegal color code");

    // an accepted non-tab byte is rendered as itself, through the work stage and the
    // result register, when that register is free in the cycle after acceptance
    a_passthru: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tdata != tesh_pkg::CHAR_TAB ##1 m_tready
            |=> m_tvalid && m_tlast && m_tdata == $past(s_tdata, 2))
        else $error("source byte not rendered as itself");

endmodule

bind tab_expand_syntax_highlighter tesh_checker u_tesh_checker (.*);

/* tb/sv/tab_expand_syntax_highlighter_tb.sv */
// Self-checking testbench for the tab-expanding syntax highlighter.
module tab_expand_syntax_highlighter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAB_STOP = tesh_pkg::TAB_STOP_DEF;
    localparam int HOLD_LONG = 300;

    typedef enum logic [1:0] {ROW_CHAR, ROW_TYPED, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic [7:0] chr;
        logic       rs;
        logic [1:0] color;
        logic       addr;
        logic       val;
    } row_t;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] color;
        logic       last;
    } rendered_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic       cfg_addr = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] char_code
    logic       s_tuser = 1'b0;    // [0] row_start
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [7:0] render_char
    logic [1:0] m_tuser;           // [1:0] color
    logic       m_tlast;

    // predictor copy of the registers and row state
    logic        hl_numbers;
    logic        hl_strings;
    int unsigned col_pos;
    logic [1:0]  quote_open;
    logic        last_sep;
    logic        last_num;
    logic        last_bslash;

    rendered_t render_q[$];
    int        mismatches = 0;
    logic      no_gaps = 1'b0;
    logic      hold_req = 1'b0;
    row_t      dir_tab[$];

    tab_expand_syntax_highlighter #(.TAB_STOP(TAB_STOP)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function automatic logic breaks_token(input logic [7:0] c);
        case (c)
            tesh_pkg::CHAR_NUL, tesh_pkg::CHAR_SPACE,
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: return 1'b1;
            // , . ( ) + - / * = ~ % < > [ ] ; ' "
            8'h2C, 8'h2E, 8'h28, 8'h29, 8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h3D,
            8'h7E, 8'h25, 8'h3C, 8'h3E, 8'h5B, 8'h5D, 8'h3B, 8'h27, 8'h22: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void clear_row();
        col_pos = 0;
        quote_open = tesh_pkg::QUOTE_NONE;
        last_sep = 1'b1;
        last_num = 1'b0;
        last_bslash = 1'b0;
    endfunction

    // appends one expected beat at the tail of the queue
    function automatic void expect_beat(input logic [7:0] ch, input logic [1:0] cl,
                                        input logic last);
        rendered_t b;
        b.ch = ch;
        b.color = cl;
        b.last = last;
        render_q.insert(render_q.size(), b);
    endfunction

    // color of one rendered byte; advances the highlight state
    function automatic logic [1:0] color_of(input logic [7:0] c);
        logic [1:0] q;
        logic       in_str;
        logic [1:0] cl;
        q = (c == tesh_pkg::CHAR_DQUOTE) ? tesh_pkg::QUOTE_DOUBLE :
            (c == tesh_pkg::CHAR_SQUOTE) ? tesh_pkg::QUOTE_SINGLE : tesh_pkg::QUOTE_NONE;
        in_str = 1'b0;
        cl = tesh_pkg::COLOR_DEFAULT;
        if (hl_strings) begin
            if (quote_open != tesh_pkg::QUOTE_NONE) begin
                if (q == quote_open && !last_bslash) begin
                    quote_open = tesh_pkg::QUOTE_NONE;
                end
                in_str = 1'b1;
            end else if (q != tesh_pkg::QUOTE_NONE) begin
                quote_open = q;
                in_str = 1'b1;
            end
        end
        if (in_str) begin
            cl = tesh_pkg::COLOR_STRING;
        end else if ((hl_numbers && c >= tesh_pkg::CHAR_ZERO && c <= tesh_pkg::CHAR_NINE
                      && (last_sep || last_num))
                     || (c == tesh_pkg::CHAR_DOT && last_num)) begin
            cl = tesh_pkg::COLOR_NUMBER;
        end
        last_sep = breaks_token(c);
        last_num = (cl == tesh_pkg::COLOR_NUMBER);
        last_bslash = (c == tesh_pkg::CHAR_BACKSLASH);
        return cl;
    endfunction

    function automatic void predict_render(input logic [7:0] c, input logic rs);
        int unsigned n;
        if (rs) begin
            clear_row();
        end
        if (c == tesh_pkg::CHAR_TAB) begin
            n = TAB_STOP - col_pos;
            for (int unsigned k = 0; k < n; k++) begin
                expect_beat(tesh_pkg::CHAR_SPACE, color_of(tesh_pkg::CHAR_SPACE), k + 1 == n);
            end
            col_pos = 0;
        end else begin
            expect_beat(c, color_of(c), 1'b1);
            col_pos = (col_pos + 1) % TAB_STOP;
        end
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_char(input logic [7:0] c, input logic rs, input logic typed,
                             input logic [1:0] color);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata = c;
        s_tuser = rs;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_render(c, rs);
        if (typed) begin
            // hand-typed expectation for a plain byte replaces the predicted one
            void'(render_q.pop_back());
            expect_beat(c, color, 1'b1);
        end
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic val);
        s_tvalid = 1'b0;
        while (render_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr = addr;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        if (addr == tesh_pkg::REG_HL_NUMBERS) begin
            hl_numbers = val;
        end else begin
            hl_strings = val;
        end
    endtask

    // biased toward digits, dots, quotes, backslashes and tabs
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return tesh_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
        if (r < 28) return tesh_pkg::CHAR_DOT;
        if (r < 36) return $urandom_range(0, 1) ? tesh_pkg::CHAR_DQUOTE : tesh_pkg::CHAR_SQUOTE;
        if (r < 42) return tesh_pkg::CHAR_BACKSLASH;
        if (r < 50) return tesh_pkg::CHAR_TAB;
        if (r < 62) begin
            case ($urandom_range(0, 3))
                0: return tesh_pkg::CHAR_SPACE;
                1: return 8'h2C;
                2: return 8'h28;
                default: return 8'h2B;
            endcase
        end
        if (r < 80) return 8'h61 + 8'($urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    // result side
    initial begin
        int stall;
        rendered_t want;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            if (hold_req) begin
                stall = HOLD_LONG;
                hold_req = 1'b0;
            end
            repeat (stall) begin
                m_tready = 1'b0;
                @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            if (render_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected beat char=%h color=%0d last=%b",
                                        m_tdata, m_tuser, m_tlast));
            end else begin
                want = render_q.pop_front();
                if (m_tdata !== want.ch) begin
                    flag_mismatch($sformatf("render_char %h, want %h", m_tdata, want.ch));
                end
                if (m_tuser !== want.color) begin
                    flag_mismatch($sformatf("color %0d, want %0d (char %h)",
                                            m_tuser, want.color, want.ch));
                end
                if (m_tlast !== want.last) begin
                    flag_mismatch($sformatf("last_of_run %b, want %b (char %h)",
                                            m_tlast, want.last, want.ch));
                end
            end
            @(negedge aclk);
        end
    end

    // source side
    initial begin
        row_t       row;
        logic [7:0] c;
        hl_numbers = 1'b0;
        hl_strings = 1'b0;
        clear_row();

        dir_tab = '{
            '{ROW_TYPED, tesh_pkg::CHAR_NUL, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_TYPED, 8'hFF, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_TYPED, tesh_pkg::CHAR_DQUOTE, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_TYPED, 8'h35, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CFG, 8'h00, 1'b0, tesh_pkg::COLOR_DEFAULT, tesh_pkg::REG_HL_NUMBERS, 1'b1},
            '{ROW_CFG, 8'h00, 1'b0, tesh_pkg::COLOR_DEFAULT, tesh_pkg::REG_HL_STRINGS, 1'b1},
            // full tab
            '{ROW_CHAR, tesh_pkg::CHAR_TAB, 1'b1, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, 8'h61, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            // partial tab
            '{ROW_CHAR, tesh_pkg::CHAR_TAB, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, 8'h31, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, tesh_pkg::CHAR_DOT, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, 8'h32, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, 8'h78, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            // digit after letter
            '{ROW_CHAR, 8'h33, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, tesh_pkg::CHAR_DQUOTE, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, tesh_pkg::CHAR_BACKSLASH, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            // escaped quote
            '{ROW_CHAR, tesh_pkg::CHAR_DQUOTE, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, tesh_pkg::CHAR_BACKSLASH, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, tesh_pkg::CHAR_BACKSLASH, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            // still escaped
            '{ROW_CHAR, tesh_pkg::CHAR_DQUOTE, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            // closes
            '{ROW_CHAR, tesh_pkg::CHAR_DQUOTE, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, tesh_pkg::CHAR_SQUOTE, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CFG, 8'h00, 1'b0, tesh_pkg::COLOR_DEFAULT, tesh_pkg::REG_HL_STRINGS, 1'b0},
            // string kept open
            '{ROW_CHAR, tesh_pkg::CHAR_SQUOTE, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, 8'h37, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CFG, 8'h00, 1'b0, tesh_pkg::COLOR_DEFAULT, tesh_pkg::REG_HL_NUMBERS, 1'b0},
            // dot after number
            '{ROW_CHAR, tesh_pkg::CHAR_DOT, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CFG, 8'h00, 1'b0, tesh_pkg::COLOR_DEFAULT, tesh_pkg::REG_HL_NUMBERS, 1'b1},
            '{ROW_CFG, 8'h00, 1'b0, tesh_pkg::COLOR_DEFAULT, tesh_pkg::REG_HL_STRINGS, 1'b1},
            // reopened string
            '{ROW_CHAR, 8'h62, 1'b0, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, 8'h63, 1'b1, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0},
            '{ROW_CHAR, 8'hFF, 1'b1, tesh_pkg::COLOR_DEFAULT, 1'b0, 1'b0}
        };

        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (dir_tab[i]) begin
            row = dir_tab[i];
            if (row.kind == ROW_CFG) begin
                write_reg(row.addr, row.val);
            end else begin
                send_char(row.chr, row.rs, row.kind == ROW_TYPED, row.color);
            end
        end

        // all four register settings, then random ones; every other phase runs gap-free
        for (int ph = 0; ph < 6; ph++) begin
            no_gaps = 1'b0;
            write_reg(tesh_pkg::REG_HL_NUMBERS, ph < 4 ? ph[0] : 1'($urandom_range(0, 1)));
            write_reg(tesh_pkg::REG_HL_STRINGS, ph < 4 ? ph[1] : 1'($urandom_range(0, 1)));
            no_gaps = ph[0];
            for (int i = 0; i < 58; i++) begin
                if ((ph == 2 || ph == 5) && i == 15) begin
                    hold_req = 1'b1;
                end
                c = pick_char();
                send_char(c, $urandom_range(0, 19) == 0, 1'b0, tesh_pkg::COLOR_DEFAULT);
            end
        end
        s_tvalid = 1'b0;
        no_gaps = 1'b0;

        while (render_q.size() != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* files.f */
sv/tesh_pkg.sv
sv/tab_expand_syntax_highlighter.sv
sv/tesh_checker.sv
tb/sv/tab_expand_syntax_highlighter_tb.sv
